// ----- design/jcd_pkg.sv -----
// Shared types and constants for the Japanese character-set detector.
package jcd_pkg;

  localparam int unsigned SCORE_WIDTH_DEF = 16;
  localparam int unsigned OUT_SCORE_W     = 16;
  localparam int unsigned NUM_LANG        = 4;

  // Score lane order, which is also the packing order of the result beat.
  localparam int unsigned LANE_JIS  = 0;
  localparam int unsigned LANE_SJIS = 1;
  localparam int unsigned LANE_EUC  = 2;
  localparam int unsigned LANE_UTF8 = 3;

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PAREN  = 8'h28;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_J      = 8'h4A;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_Q      = 8'h51;

  typedef enum logic [1:0] {
    DEC_NONE,
    DEC_JIS,
    DEC_HIGH
  } decision_e;

  typedef enum logic [2:0] {
    ESC_IDLE,
    ESC_SEEN,
    ESC_DOLLAR,
    ESC_PAREN,
    ESC_DOLLAR_PAREN
  } esc_e;

  typedef enum logic [1:0] {
    SJ_START,
    SJ_TRAIL,
    SJ_DEAD
  } sjis_e;

  typedef enum logic [2:0] {
    EU_START,
    EU_KANA,
    EU_TRAIL,
    EU_SUPP,
    EU_DEAD
  } euc_e;

  typedef enum logic [3:0] {
    U8_START,
    U8_NEED1,
    U8_NEED2,
    U8_AFTER_E0,
    U8_AFTER_ED,
    U8_AFTER_EF,
    U8_AFTER_F0,
    U8_AFTER_F1F2,
    U8_AFTER_F3,
    U8_AFTER_F4,
    U8_DEAD
  } utf8_e;

  // Line verdict handed from the scanner to the score counters.
  typedef struct packed {
    logic [NUM_LANG-1:0] hit;   // lane scores on this line
    logic [NUM_LANG-1:0] rare;  // lane saw a rare or private lead form
  } verdict_t;

endpackage

// ----- design/jcd_scan.sv -----
// Per-line recognizers: escape detector, decision and three byte automata.
module jcd_scan
  import jcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output verdict_t   verdict_o
);

  decision_e dec_q, dec_d;
  esc_e      esc_q, esc_d;
  sjis_e     sj_q, sj_d;
  euc_e      eu_q, eu_d;
  utf8_e     u8_q, u8_d;
  logic      sj_rare_q, sj_rare_d;
  logic      eu_rare_q, eu_rare_d;
  logic      u8_rare_q, u8_rare_d;
  logic      esc_done;
  logic      cont;

  // Escape sequence recognizer and line decision.
  always_comb begin
    esc_d    = esc_q;
    esc_done = 1'b0;
    dec_d    = dec_q;
    if (dec_q == DEC_NONE) begin
      if (byte_i[7]) begin
        dec_d = DEC_HIGH;
      end else begin
        esc_d = ESC_IDLE;
        if (byte_i == CH_ESC) begin
          esc_d = ESC_SEEN;
        end else begin
          unique case (esc_q)
            ESC_SEEN: begin
              if (byte_i == CH_DOLLAR) esc_d = ESC_DOLLAR;
              else if (byte_i == CH_PAREN) esc_d = ESC_PAREN;
            end
            ESC_DOLLAR: begin
              if (byte_i == CH_B || byte_i == CH_AT) esc_done = 1'b1;
              else if (byte_i == CH_PAREN) esc_d = ESC_DOLLAR_PAREN;
            end
            ESC_PAREN: begin
              esc_done = (byte_i == CH_B) || (byte_i == CH_H) ||
                         (byte_i == CH_I) || (byte_i == CH_J);
            end
            ESC_DOLLAR_PAREN: begin
              esc_done = (byte_i == CH_D) || (byte_i == CH_O) ||
                         (byte_i == CH_P) || (byte_i == CH_Q);
            end
            default: esc_done = 1'b0;
          endcase
        end
        if (esc_done) dec_d = DEC_JIS;
      end
    end
  end

  // Shift-JIS automaton.
  always_comb begin
    sj_d      = sj_q;
    sj_rare_d = sj_rare_q;
    unique case (sj_q)
      SJ_START: begin
        case (byte_i) inside
          [8'h00:8'h7F], [8'hA1:8'hDF]: sj_d = SJ_START;
          [8'h81:8'h9F], [8'hE0:8'hFC]: begin
            sj_d = SJ_TRAIL;
            case (byte_i) inside
              8'h85, 8'h86, 8'hEB, 8'hEC, [8'hEF:8'hF9]: sj_rare_d = 1'b1;
              default: ;
            endcase
          end
          default: sj_d = SJ_DEAD;
        endcase
      end
      SJ_TRAIL: begin
        case (byte_i) inside
          [8'h40:8'h7E], [8'h80:8'hFC]: sj_d = SJ_START;
          default: sj_d = SJ_DEAD;
        endcase
      end
      default: sj_d = SJ_DEAD;
    endcase
  end

  // EUC-JP automaton.
  always_comb begin
    eu_d      = eu_q;
    eu_rare_d = eu_rare_q;
    unique case (eu_q)
      EU_START: begin
        case (byte_i) inside
          [8'h00:8'h7F]: eu_d = EU_START;
          8'h8E: eu_d = EU_KANA;
          8'h8F: begin
            eu_d      = EU_SUPP;
            eu_rare_d = 1'b1;
          end
          [8'hA9:8'hAF], [8'hF5:8'hFE]: begin
            eu_d      = EU_TRAIL;
            eu_rare_d = 1'b1;
          end
          [8'hA1:8'hFE]: eu_d = EU_TRAIL;
          default: eu_d = EU_DEAD;
        endcase
      end
      EU_KANA:  eu_d = (byte_i >= 8'hA1 && byte_i <= 8'hDF) ? EU_START : EU_DEAD;
      EU_TRAIL: eu_d = (byte_i >= 8'hA1 && byte_i <= 8'hFE) ? EU_START : EU_DEAD;
      EU_SUPP:  eu_d = (byte_i >= 8'hA1 && byte_i <= 8'hFE) ? EU_TRAIL : EU_DEAD;
      default:  eu_d = EU_DEAD;
    endcase
  end

  // UTF-8 automaton; surrogates, private use and plane 15/16 count as rare.
  assign cont = (byte_i[7:6] == 2'b10);

  always_comb begin
    u8_d      = U8_DEAD;
    u8_rare_d = u8_rare_q;
    unique case (u8_q)
      U8_START: begin
        case (byte_i) inside
          [8'h00:8'h7F]: u8_d = U8_START;
          [8'hC2:8'hDF]: u8_d = U8_NEED1;
          8'hE0:         u8_d = U8_AFTER_E0;
          [8'hE1:8'hEC]: u8_d = U8_NEED2;
          8'hED:         u8_d = U8_AFTER_ED;
          8'hEE: begin
            u8_d      = U8_NEED2;
            u8_rare_d = 1'b1;
          end
          8'hEF:         u8_d = U8_AFTER_EF;
          8'hF0:         u8_d = U8_AFTER_F0;
          8'hF1, 8'hF2:  u8_d = U8_AFTER_F1F2;
          8'hF3:         u8_d = U8_AFTER_F3;
          8'hF4:         u8_d = U8_AFTER_F4;
          default:       u8_d = U8_DEAD;
        endcase
      end
      U8_NEED1: if (cont) u8_d = U8_START;
      U8_NEED2: if (cont) u8_d = U8_NEED1;
      U8_AFTER_E0: if (byte_i >= 8'hA0 && byte_i <= 8'hBF) u8_d = U8_NEED1;
      U8_AFTER_ED: begin
        if (cont) begin
          u8_d = U8_NEED1;
          if (byte_i >= 8'hA0) u8_rare_d = 1'b1;
        end
      end
      U8_AFTER_EF: begin
        if (cont) begin
          u8_d = U8_NEED1;
          if (byte_i <= 8'hA3) u8_rare_d = 1'b1;
        end
      end
      U8_AFTER_F0: if (byte_i >= 8'h90 && byte_i <= 8'hBF) u8_d = U8_NEED2;
      U8_AFTER_F1F2: if (cont) u8_d = U8_NEED2;
      U8_AFTER_F3: begin
        if (cont) begin
          u8_d = U8_NEED2;
          if (byte_i >= 8'hB0) u8_rare_d = 1'b1;
        end
      end
      U8_AFTER_F4: begin
        if (byte_i >= 8'h80 && byte_i <= 8'h8F) begin
          u8_d      = U8_NEED2;
          u8_rare_d = 1'b1;
        end
      end
      default: u8_d = U8_DEAD;
    endcase
  end

  // Verdict reflects the state after this byte; used only on the last byte.
  always_comb begin
    verdict_o = '0;
    verdict_o.hit[LANE_JIS]   = (dec_d == DEC_JIS);
    verdict_o.hit[LANE_SJIS]  = (dec_d == DEC_HIGH) && (sj_d == SJ_START);
    verdict_o.hit[LANE_EUC]   = (dec_d == DEC_HIGH) && (eu_d == EU_START);
    verdict_o.hit[LANE_UTF8]  = (dec_d == DEC_HIGH) && (u8_d == U8_START);
    verdict_o.rare[LANE_SJIS] = sj_rare_d;
    verdict_o.rare[LANE_EUC]  = eu_rare_d;
    verdict_o.rare[LANE_UTF8] = u8_rare_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q     <= DEC_NONE;
      esc_q     <= ESC_IDLE;
      sj_q      <= SJ_START;
      eu_q      <= EU_START;
      u8_q      <= U8_START;
      sj_rare_q <= 1'b0;
      eu_rare_q <= 1'b0;
      u8_rare_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        dec_q     <= DEC_NONE;
        esc_q     <= ESC_IDLE;
        sj_q      <= SJ_START;
        eu_q      <= EU_START;
        u8_q      <= U8_START;
        sj_rare_q <= 1'b0;
        eu_rare_q <= 1'b0;
        u8_rare_q <= 1'b0;
      end else begin
        dec_q     <= dec_d;
        esc_q     <= esc_d;
        sj_q      <= sj_d;
        eu_q      <= eu_d;
        u8_q      <= u8_d;
        sj_rare_q <= sj_rare_d;
        eu_rare_q <= eu_rare_d;
        u8_rare_q <= u8_rare_d;
      end
    end
  end

endmodule

// ----- design/jcd_score.sv -----
// Saturating score counters, one lane per candidate encoding.
module jcd_score
  import jcd_pkg::*;
#(
  parameter int unsigned SCORE_WIDTH = SCORE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  update_i,
  input  verdict_t              verdict_i,
  output logic [OUT_SCORE_W-1:0] score_o [NUM_LANG]
);

  localparam logic [SCORE_WIDTH-1:0] ScoreMax = {SCORE_WIDTH{1'b1}};

  logic [SCORE_WIDTH-1:0] total_q [NUM_LANG];

  for (genvar g = 0; g < NUM_LANG; g++) begin : g_lane
    logic [SCORE_WIDTH:0]   sum;
    logic [SCORE_WIDTH-1:0] total_d;

    // A rare form scores one point, a clean line two.
    assign sum     = {1'b0, total_q[g]} +
                     (verdict_i.rare[g] ? (SCORE_WIDTH+1)'(1) : (SCORE_WIDTH+1)'(2));
    assign total_d = sum[SCORE_WIDTH] ? ScoreMax : sum[SCORE_WIDTH-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        total_q[g] <= '0;
      end else if (update_i && verdict_i.hit[g]) begin
        total_q[g] <= total_d;
      end
    end

    assign score_o[g] = OUT_SCORE_W'(total_q[g]);
  end

endmodule

// ----- design/japanese_charset_detector_unit.sv -----
// Top level of the Japanese character-set detector.
//
//   Port group   Dir   Beat content (low bit first)
//   s_axis_*     in    tdata: data_byte[7:0]; tlast: last_byte
//   m_axis_*     out   tdata: jis, sjis, euc, utf8 scores, 16 bits each
//
// One byte beat is taken per cycle while no last byte waits for a stalled
// result. A byte is held in the input register, then the recognizers and
// score counters advance on it; a line's result beat turns valid once its last
// byte has left the input register and updated the score counters. The score
// counters double as the result register, so the output stays steady while
// the downstream side stalls. Only a last byte waits for a stalled result;
// other bytes keep flowing. Reset clears the counters and all recognizers.
module japanese_charset_detector_unit
  import jcd_pkg::*;
#(
  parameter int unsigned SCORE_WIDTH = SCORE_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] jis_score, [31:16] sjis_score, [47:32] euc_score, [63:48] utf8_score
  output logic [63:0] m_axis_tdata_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  logic       advance;
  logic       load_in;
  verdict_t   verdict;
  logic [OUT_SCORE_W-1:0] score [NUM_LANG];

  // A held byte moves on unless it closes a line while the previous result
  // is still waiting downstream.
  assign advance         = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign load_in         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  jcd_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .verdict_o (verdict)
  );

  jcd_score #(
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_score (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .update_i  (advance && in_last_q),
    .verdict_i (verdict),
    .score_o   (score)
  );

  // Result beat is pending from the end of a line until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {score[LANE_UTF8], score[LANE_EUC],
                            score[LANE_SJIS], score[LANE_JIS]};

endmodule

// ----- design/jcd_checker.sv -----
// Port-level checker for the detector, bound to the top level.
module jcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o
);

  // A pending result beat keeps its scores until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // Input backpressure only comes from a stalled result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a stalled result");

  // A fresh result beat only follows a last byte that has been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |->
      $past(s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i, 2))
    else $error("result beat without a line end");

endmodule

bind japanese_charset_detector_unit jcd_checker u_jcd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ----- tb/jcd_score_checker.sv -----
// Scoreboard for the Japanese character-set detector: predicts score beats and compares them.
`timescale 1ns / 1ps

module jcd_score_checker
  import jcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [63:0] m_axis_tdata_i,
  output int          fail_count_o,
  output int          pending_o
);

  // Running totals, kept across lines.
  logic [SCORE_WIDTH_DEF-1:0] totals [NUM_LANG];

  // Per-line recognizer state.
  decision_e line_dec;
  esc_e      esc_st;
  sjis_e     sj_st;
  euc_e      eu_st;
  utf8_e     u8_st;
  logic      sj_rare, eu_rare, u8_rare;

  logic [63:0] expected_scores [$];
  int          mismatches;

  function automatic bit in_span(logic [7:0] b, logic [7:0] lo, logic [7:0] hi);
    return b >= lo && b <= hi;
  endfunction

  function automatic logic [SCORE_WIDTH_DEF-1:0] bump(logic [SCORE_WIDTH_DEF-1:0] t,
                                                      int unsigned add);
    logic [SCORE_WIDTH_DEF:0] sum;
    sum = {1'b0, t} + (SCORE_WIDTH_DEF+1)'(add);
    return sum[SCORE_WIDTH_DEF] ? '1 : sum[SCORE_WIDTH_DEF-1:0];
  endfunction

  function automatic string lane_label(int l);
    case (l)
      LANE_JIS:  return "jis_score";
      LANE_SJIS: return "sjis_score";
      LANE_EUC:  return "euc_score";
      default:   return "utf8_score";
    endcase
  endfunction

  function automatic void clear_line();
    line_dec = DEC_NONE;
    esc_st   = ESC_IDLE;
    sj_st    = SJ_START;
    eu_st    = EU_START;
    u8_st    = U8_START;
    sj_rare  = 1'b0;
    eu_rare  = 1'b0;
    u8_rare  = 1'b0;
  endfunction

  // Returns 1 when this byte completes an ISO-2022-JP escape sequence.
  // An ESC always restarts the sequence; anything unexpected drops back to idle.
  function automatic bit escape_done(logic [7:0] b);
    esc_e prev;
    prev   = esc_st;
    esc_st = ESC_IDLE;
    if (b == CH_ESC) begin
      esc_st = ESC_SEEN;
      return 1'b0;
    end
    case (prev)
      ESC_SEEN: begin
        if (b == CH_DOLLAR) esc_st = ESC_DOLLAR;
        else if (b == CH_PAREN) esc_st = ESC_PAREN;
        return 1'b0;
      end
      ESC_DOLLAR: begin
        if (b == CH_B || b == CH_AT) return 1'b1;
        if (b == CH_PAREN) esc_st = ESC_DOLLAR_PAREN;
        return 1'b0;
      end
      ESC_PAREN:        return b == CH_B || b == CH_H || b == CH_I || b == CH_J;
      ESC_DOLLAR_PAREN: return b == CH_D || b == CH_O || b == CH_P || b == CH_Q;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic void step_sjis(logic [7:0] b);
    case (sj_st)
      SJ_START: begin
        if (b <= 8'h7F || in_span(b, 8'hA1, 8'hDF)) begin
          sj_st = SJ_START;
        end else if (in_span(b, 8'h81, 8'h9F) || in_span(b, 8'hE0, 8'hFC)) begin
          if (b == 8'h85 || b == 8'h86 || b == 8'hEB || b == 8'hEC || in_span(b, 8'hEF, 8'hF9))
            sj_rare = 1'b1;
          sj_st = SJ_TRAIL;
        end else begin
          sj_st = SJ_DEAD;
        end
      end
      SJ_TRAIL: sj_st = (in_span(b, 8'h40, 8'h7E) || in_span(b, 8'h80, 8'hFC)) ? SJ_START : SJ_DEAD;
      default:  sj_st = SJ_DEAD;
    endcase
  endfunction

  function automatic void step_euc(logic [7:0] b);
    case (eu_st)
      EU_START: begin
        if (b <= 8'h7F) begin
          eu_st = EU_START;
        end else if (b == 8'h8E) begin
          eu_st = EU_KANA;
        end else if (b == 8'h8F) begin
          eu_st   = EU_SUPP;
          eu_rare = 1'b1;
        end else if (in_span(b, 8'hA1, 8'hFE)) begin
          if (in_span(b, 8'hA9, 8'hAF) || in_span(b, 8'hF5, 8'hFE)) eu_rare = 1'b1;
          eu_st = EU_TRAIL;
        end else begin
          eu_st = EU_DEAD;
        end
      end
      EU_KANA:  eu_st = in_span(b, 8'hA1, 8'hDF) ? EU_START : EU_DEAD;
      EU_TRAIL: eu_st = in_span(b, 8'hA1, 8'hFE) ? EU_START : EU_DEAD;
      EU_SUPP:  eu_st = in_span(b, 8'hA1, 8'hFE) ? EU_TRAIL : EU_DEAD;
      default:  eu_st = EU_DEAD;
    endcase
  endfunction

  function automatic void step_utf8(logic [7:0] b);
    bit    cont;
    utf8_e nxt;
    cont = in_span(b, 8'h80, 8'hBF);
    nxt  = U8_DEAD;
    case (u8_st)
      U8_START: begin
        if (b <= 8'h7F) nxt = U8_START;
        else if (in_span(b, 8'hC2, 8'hDF)) nxt = U8_NEED1;
        else if (b == 8'hE0) nxt = U8_AFTER_E0;
        else if (in_span(b, 8'hE1, 8'hEC)) nxt = U8_NEED2;
        else if (b == 8'hED) nxt = U8_AFTER_ED;
        else if (b == 8'hEE) begin
          // Private-use lead.
          nxt     = U8_NEED2;
          u8_rare = 1'b1;
        end
        else if (b == 8'hEF) nxt = U8_AFTER_EF;
        else if (b == 8'hF0) nxt = U8_AFTER_F0;
        else if (b == 8'hF1 || b == 8'hF2) nxt = U8_AFTER_F1F2;
        else if (b == 8'hF3) nxt = U8_AFTER_F3;
        else if (b == 8'hF4) nxt = U8_AFTER_F4;
      end
      U8_NEED1:    if (cont) nxt = U8_START;
      U8_NEED2:    if (cont) nxt = U8_NEED1;
      U8_AFTER_E0: if (in_span(b, 8'hA0, 8'hBF)) nxt = U8_NEED1;
      U8_AFTER_ED: if (cont) begin
        nxt = U8_NEED1;
        if (b >= 8'hA0) u8_rare = 1'b1;
      end
      U8_AFTER_EF: if (cont) begin
        nxt = U8_NEED1;
        if (b <= 8'hA3) u8_rare = 1'b1;
      end
      U8_AFTER_F0:   if (in_span(b, 8'h90, 8'hBF)) nxt = U8_NEED2;
      U8_AFTER_F1F2: if (cont) nxt = U8_NEED2;
      U8_AFTER_F3: if (cont) begin
        nxt = U8_NEED2;
        if (b >= 8'hB0) u8_rare = 1'b1;
      end
      U8_AFTER_F4: if (in_span(b, 8'h80, 8'h8F)) begin
        nxt     = U8_NEED2;
        u8_rare = 1'b1;
      end
      default: nxt = U8_DEAD;
    endcase
    u8_st = nxt;
  endfunction

  // Advances the line model by one byte; a last byte closes the line and
  // queues the score beat that the block owes for it.
  function automatic void take_byte(logic [7:0] b, logic last);
    if (line_dec == DEC_NONE) begin
      if (b[7]) line_dec = DEC_HIGH;
      else if (escape_done(b)) line_dec = DEC_JIS;
    end
    step_sjis(b);
    step_euc(b);
    step_utf8(b);
    if (last) begin
      if (line_dec == DEC_JIS) begin
        totals[LANE_JIS] = bump(totals[LANE_JIS], 2);
      end else if (line_dec == DEC_HIGH) begin
        if (sj_st == SJ_START) totals[LANE_SJIS] = bump(totals[LANE_SJIS], sj_rare ? 1 : 2);
        if (eu_st == EU_START) totals[LANE_EUC] = bump(totals[LANE_EUC], eu_rare ? 1 : 2);
        if (u8_st == U8_START) totals[LANE_UTF8] = bump(totals[LANE_UTF8], u8_rare ? 1 : 2);
      end
      expected_scores.push_back({totals[LANE_UTF8][OUT_SCORE_W-1:0],
                                 totals[LANE_EUC][OUT_SCORE_W-1:0],
                                 totals[LANE_SJIS][OUT_SCORE_W-1:0],
                                 totals[LANE_JIS][OUT_SCORE_W-1:0]});
      clear_line();
    end
  endfunction

  function automatic void check_result(logic [63:0] got);
    logic [63:0] want;
    if (expected_scores.size() == 0) begin
      $error("score beat %h arrived with no line outstanding", got);
      mismatches++;
      return;
    end
    want = expected_scores.pop_front();
    for (int l = 0; l < NUM_LANG; l++) begin
      if (got[l*OUT_SCORE_W +: OUT_SCORE_W] !== want[l*OUT_SCORE_W +: OUT_SCORE_W]) begin
        $error("%s: expected %0d, got %0d", lane_label(l),
               want[l*OUT_SCORE_W +: OUT_SCORE_W], got[l*OUT_SCORE_W +: OUT_SCORE_W]);
        mismatches++;
      end
    end
  endfunction

  // The output side is checked before the input side is taken; a line's beat
  // can never leave in the same cycle as its last byte enters.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NUM_LANG; l++) totals[l] = '0;
      clear_line();
      expected_scores.delete();
      mismatches = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_result(m_axis_tdata_i);
      if (s_axis_tvalid_i && s_axis_tready_i) take_byte(s_axis_tdata_i, s_axis_tlast_i);
    end
    pending_o    <= expected_scores.size();
    fail_count_o <= mismatches;
  end

endmodule

// ----- tb/japanese_charset_detector_unit_tb.sv -----
// Top of the testbench for the Japanese character-set detector: stimulus and verdict.
`timescale 1ns / 1ps

module japanese_charset_detector_unit_tb;
  import jcd_pkg::*;

  // Length of the long downstream hold-off that forces the block to back up.
  localparam int HOLD_CYCLES = 400;

  typedef enum int {
    LK_SJIS,
    LK_EUC,
    LK_UTF8,
    LK_JIS,
    LK_NOISE
  } line_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [63:0] m_tdata;

  int fail_count;
  int pending;

  // Knobs shared by the stimulus and the downstream model. The percentages
  // are per-cycle chances of the sender idling and the receiver stalling.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_token    = 0;
  int bytes_sent    = 0;

  // The line currently being assembled, first byte at index 0.
  logic [7:0] line_buf [$];

  japanese_charset_detector_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  jcd_score_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs somewhere.
  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Downstream model. Normally it stalls at random by stall_pct. Each time the
  // stimulus bumps hold_token, it holds tready low for the long hold-off,
  // counted here in hold_left, so that the result register fills and the block
  // has to push back on its byte input.
  int hold_left = 0;
  int hold_seen = 0;

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [7:0] rnd_byte(int unsigned lo, int unsigned hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic void add_cont();
    line_buf.push_back(rnd_byte(8'h80, 8'hBF));
  endfunction

  // Appends one of the complete escape sequences that switch character sets.
  function automatic void add_escape();
    line_buf.push_back(CH_ESC);
    case ($urandom_range(9))
      0: begin line_buf.push_back(CH_DOLLAR); line_buf.push_back(CH_B); end
      1: begin line_buf.push_back(CH_DOLLAR); line_buf.push_back(CH_AT); end
      2: begin line_buf.push_back(CH_PAREN); line_buf.push_back(CH_B); end
      3: begin line_buf.push_back(CH_PAREN); line_buf.push_back(CH_H); end
      4: begin line_buf.push_back(CH_PAREN); line_buf.push_back(CH_I); end
      5: begin line_buf.push_back(CH_PAREN); line_buf.push_back(CH_J); end
      6: begin
        line_buf.push_back(CH_DOLLAR); line_buf.push_back(CH_PAREN); line_buf.push_back(CH_D);
      end
      7: begin
        line_buf.push_back(CH_DOLLAR); line_buf.push_back(CH_PAREN); line_buf.push_back(CH_O);
      end
      8: begin
        line_buf.push_back(CH_DOLLAR); line_buf.push_back(CH_PAREN); line_buf.push_back(CH_P);
      end
      default: begin
        line_buf.push_back(CH_DOLLAR); line_buf.push_back(CH_PAREN); line_buf.push_back(CH_Q);
      end
    endcase
  endfunction

  function automatic void add_sjis_char();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 3) begin
      line_buf.push_back(rnd_byte(8'h00, 8'h7F));
    end else if (r == 3) begin
      line_buf.push_back(rnd_byte(8'hA1, 8'hDF));
    end else begin
      line_buf.push_back($urandom_range(1) ? rnd_byte(8'h81, 8'h9F) : rnd_byte(8'hE0, 8'hFC));
      line_buf.push_back($urandom_range(2) == 0 ? rnd_byte(8'h40, 8'h7E) : rnd_byte(8'h80, 8'hFC));
    end
  endfunction

  function automatic void add_euc_char();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 3) begin
      line_buf.push_back(rnd_byte(8'h00, 8'h7F));
    end else if (r == 3) begin
      line_buf.push_back(8'h8E);
      line_buf.push_back(rnd_byte(8'hA1, 8'hDF));
    end else if (r == 4) begin
      line_buf.push_back(8'h8F);
      line_buf.push_back(rnd_byte(8'hA1, 8'hFE));
      line_buf.push_back(rnd_byte(8'hA1, 8'hFE));
    end else begin
      line_buf.push_back(rnd_byte(8'hA1, 8'hFE));
      line_buf.push_back(rnd_byte(8'hA1, 8'hFE));
    end
  endfunction

  // Well-formed UTF-8, including surrogate, private-use and supplementary
  // private ranges that count as rare forms.
  function automatic void add_utf8_char();
    int unsigned r;
    logic [7:0]  lead;
    r = $urandom_range(9);
    if (r < 3) begin
      line_buf.push_back(rnd_byte(8'h00, 8'h7F));
    end else if (r == 3) begin
      line_buf.push_back(rnd_byte(8'hC2, 8'hDF));
      add_cont();
    end else if (r < 7) begin
      lead = rnd_byte(8'hE0, 8'hEF);
      line_buf.push_back(lead);
      if (lead == 8'hE0) line_buf.push_back(rnd_byte(8'hA0, 8'hBF));
      else add_cont();
      add_cont();
    end else begin
      lead = rnd_byte(8'hF0, 8'hF4);
      line_buf.push_back(lead);
      if (lead == 8'hF0) line_buf.push_back(rnd_byte(8'h90, 8'hBF));
      else if (lead == 8'hF4) line_buf.push_back(rnd_byte(8'h80, 8'h8F));
      else add_cont();
      add_cont();
      add_cont();
    end
  endfunction

  // Builds one random line into line_buf. Most lines are well formed in one
  // encoding; some get a byte corrupted or the tail cut, some are pure noise.
  function automatic void make_line(int unsigned max_chars);
    int unsigned r;
    int unsigned n_chars;
    line_kind_e  kind;
    line_buf.delete();
    r = $urandom_range(99);
    n_chars = $urandom_range(max_chars, 1);
    if (r < 22) kind = LK_SJIS;
    else if (r < 44) kind = LK_EUC;
    else if (r < 66) kind = LK_UTF8;
    else if (r < 84) kind = LK_JIS;
    else kind = LK_NOISE;
    for (int unsigned i = 0; i < n_chars; i++) begin
      case (kind)
        LK_SJIS: add_sjis_char();
        LK_EUC:  add_euc_char();
        LK_UTF8: add_utf8_char();
        LK_JIS: begin
          case ($urandom_range(5))
            0, 1:    add_escape();
            2:       begin line_buf.push_back(CH_ESC); line_buf.push_back(rnd_byte(0, 8'h7F)); end
            3:       line_buf.push_back(rnd_byte(8'h80, 8'hFF));
            default: line_buf.push_back(rnd_byte(8'h00, 8'h7F));
          endcase
        end
        default: line_buf.push_back(rnd_byte(8'h00, 8'hFF));
      endcase
    end
    if (kind != LK_NOISE && $urandom_range(99) < 12) begin
      if (line_buf.size() > 1 && $urandom_range(1)) line_buf.pop_back();
      else line_buf[$urandom_range(line_buf.size() - 1)] = rnd_byte(8'h00, 8'hFF);
    end
  endfunction

  // Offers one byte beat and returns once the block has taken it. Idle
  // cycles ahead of the beat follow send_idle_pct.
  task automatic push_byte(logic [7:0] b, logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) push_byte(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic send_bytes(input logic [7:0] bytes [$]);
    line_buf = bytes;
    send_line();
  endtask

  task automatic run_phase(int tx_idle, int rx_stall, int n_bytes);
    int target;
    target        = bytes_sent + n_bytes;
    send_idle_pct = tx_idle;
    stall_pct     = rx_stall;
    while (bytes_sent < target) begin
      make_line(6);
      send_line();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines, sent back to back.
    send_bytes('{CH_ESC, CH_DOLLAR, CH_B});            // complete escape
    send_bytes('{8'h00});                              // neither escape nor 8-bit byte
    send_bytes('{8'hFF});                              // invalid in every encoding
    send_bytes('{CH_ESC, CH_ESC, CH_PAREN, CH_J});     // second ESC restarts the sequence
    send_bytes('{8'h82, 8'hA0});                       // plain Shift-JIS character
    send_bytes('{8'h8F, 8'hA1, 8'hFE});                // supplementary EUC-JP character
    send_bytes('{8'hED, 8'hA0, 8'h80});                // UTF-8 surrogate range
    send_bytes('{8'hE3, 8'h81});                       // character cut off at line end
    send_bytes('{CH_ESC, CH_DOLLAR, CH_PAREN, CH_Q});  // four-byte escape

    // Random lines under each idling pattern.
    run_phase(0, 0, 390);
    run_phase(79, 0, 390);
    run_phase(0, 79, 390);

    // Long downstream hold-off while the sender keeps pushing short lines.
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_token    = hold_token + 1;
    repeat (20) begin
      make_line(1);
      send_line();
    end

    run_phase(26, 26, 390);
    run_phase(0, 0, 390);

    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (pending != 0) $error("%0d line score beats never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- japanese_charset_detector_unit.f -----
design/jcd_pkg.sv
design/jcd_scan.sv
design/jcd_score.sv
design/japanese_charset_detector_unit.sv
design/jcd_checker.sv
tb/jcd_score_checker.sv
tb/japanese_charset_detector_unit_tb.sv
